// File: rtl/core/prime_sieve_next_prime_query_unit_defines.svh
// Assertion macros shared by the prime sieve query unit.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef PRIME_SIEVE_NEXT_PRIME_QUERY_UNIT_DEFINES_SVH
`define PRIME_SIEVE_NEXT_PRIME_QUERY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PSQ_ASSERT_NOW(name, cond, check, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSQ_ASSERT_NEXT(name, cond, check, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
    else $error(msg);

`endif

// File: rtl/core/psq_pkg.sv
package psq_pkg;

  // Field and bitmap geometry.
  localparam int VALUE_W = 16;
  localparam int WORD_W  = 32;
  localparam int BIT_W   = 5;
  localparam int WIDX_W  = VALUE_W - BIT_W;
  localparam int I_W     = 9;

  localparam logic [VALUE_W-1:0] LIMIT_RESET = 16'hFFFF;
  localparam logic [I_W-1:0]     FIRST_PRIME = 9'd2;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_SIEVE_CHK,
    ST_SIEVE_RD,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Bitmap read address source.
  typedef enum logic [2:0] {
    RD_I,
    RD_J,
    RD_QUERY,
    RD_SCAN,
    RD_SCAN_NEXT
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    lim_load;
    logic    clr_init;
    logic    clr_write;
    logic    i_init;
    logic    i_inc;
    logic    j_load;
    logic    j_inc;
    logic    mark_write;
    logic    q_load;
    logic    scan_next;
    logic    res_load;
    rd_sel_t rd_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic sq_over;
    logic i_composite;
    logic j_over;
    logic scan_hit;
    logic scan_end;
  } sts_t;

endpackage

// File: rtl/core/psq_ram.sv
module psq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/psq_ctrl.sv
`include "prime_sieve_next_prime_query_unit_defines.svh"

module psq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  output psq_pkg::cmd_t cmd,
  input  psq_pkg::sts_t sts
);
  import psq_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   cfg_fire;
  logic   in_fire;
  logic   out_free;

  // The limit register always takes a write; a write restarts the sieve.
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_stall  = (state != ST_IDLE) || cfg_valid;
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Result slot: filled by a finished scan, emptied by a transaction.
  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (cmd.res_load) begin
      out_valid_next = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    if (cfg_fire) begin
      state_next = ST_CLEAR;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (sts.clr_last) begin
            state_next = ST_SIEVE_CHK;
          end
        end
        ST_SIEVE_CHK: begin
          state_next = sts.sq_over ? ST_IDLE : ST_SIEVE_RD;
        end
        ST_SIEVE_RD: begin
          state_next = sts.i_composite ? ST_SIEVE_CHK : ST_MARK_RD;
        end
        ST_MARK_RD: begin
          state_next = sts.j_over ? ST_SIEVE_CHK : ST_MARK_WR;
        end
        ST_MARK_WR: begin
          state_next = ST_MARK_RD;
        end
        ST_IDLE: begin
          if (in_fire) begin
            state_next = ST_SCAN;
          end
        end
        ST_SCAN: begin
          if ((sts.scan_hit || sts.scan_end) && out_free) begin
            state_next = ST_IDLE;
          end
        end
        default: state_next = ST_CLEAR;
      endcase
    end
  end

  // Datapath commands.
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_QUERY;
    if (cfg_fire) begin
      cmd.lim_load = 1'b1;
      cmd.clr_init = 1'b1;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          cmd.clr_write = 1'b1;
          cmd.i_init    = 1'b1;
        end
        ST_SIEVE_CHK: begin
          cmd.rd_sel = RD_I;
          cmd.j_load = 1'b1;
        end
        ST_SIEVE_RD: begin
          cmd.i_inc = sts.i_composite;
        end
        ST_MARK_RD: begin
          cmd.rd_sel = RD_J;
          cmd.i_inc  = sts.j_over;
        end
        ST_MARK_WR: begin
          cmd.mark_write = 1'b1;
          cmd.j_inc      = 1'b1;
        end
        ST_IDLE: begin
          cmd.rd_sel = RD_QUERY;
          cmd.q_load = in_fire;
        end
        ST_SCAN: begin
          if (sts.scan_hit || sts.scan_end) begin
            cmd.rd_sel   = RD_SCAN;
            cmd.res_load = out_free;
          end else begin
            cmd.rd_sel    = RD_SCAN_NEXT;
            cmd.scan_next = 1'b1;
          end
        end
        default: cmd.rd_sel = RD_QUERY;
      endcase
    end
  end

  // Checks on the sequencing of this controller.
  `PSQ_ASSERT_NEXT(a_accept_scans, in_fire, state == ST_SCAN, "accepted query did not start a scan")
  `PSQ_ASSERT_NEXT(a_cfg_clears, cfg_fire, state == ST_CLEAR, "limit write did not restart the sieve")
  `PSQ_ASSERT_NEXT(a_result_shown, cmd.res_load, out_valid, "loaded result not presented")
  `PSQ_ASSERT_NOW(a_mark_after_read, state == ST_MARK_WR, $past(state) == ST_MARK_RD, "mark write without read")

endmodule

// File: rtl/core/psq_dp.sv
module psq_dp #(
  parameter int MAX_VALUE = 65535
) (
  input  logic                          clk,
  input  logic                          rst,
  input  psq_pkg::cmd_t                 cmd,
  output psq_pkg::sts_t                 sts,
  input  logic [psq_pkg::VALUE_W-1:0]   query_value,
  input  logic [psq_pkg::VALUE_W-1:0]   sieve_limit,
  output logic [psq_pkg::VALUE_W-1:0]   next_prime,
  output logic [psq_pkg::VALUE_W-1:0]   prime_gap,
  output logic                          found
);
  import psq_pkg::*;

  localparam int DEPTH  = MAX_VALUE / WORD_W + 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [31:0]        MAX_V32   = 32'(MAX_VALUE);
  localparam logic [VALUE_W-1:0] LIM_RESET =
    (MAX_VALUE < 65535) ? VALUE_W'(MAX_VALUE) : LIMIT_RESET;
  localparam logic [ADDR_W-1:0]  CLR_LAST  = ADDR_W'(DEPTH - 1);
  // Zero and one are never prime.
  localparam logic [WORD_W-1:0]  LOW_NONPRIME = WORD_W'(3);
  localparam logic [WORD_W-1:0]  ONES = '1;
  localparam logic [BIT_W-1:0]   TOP_BIT = BIT_W'(WORD_W - 1);

  logic [VALUE_W-1:0]   lim;
  logic [ADDR_W-1:0]    clr_cnt;
  logic [I_W-1:0]       i;
  logic [VALUE_W:0]     j;
  logic [VALUE_W-1:0]   q;
  logic [WIDX_W-1:0]    scan_word;
  logic [2*I_W-1:0]     sq;
  logic [WIDX_W-1:0]    scan_word_inc;
  logic [WIDX_W-1:0]    q_word;
  logic [WIDX_W-1:0]    lim_word;
  logic [BIT_W-1:0]     lo;
  logic [BIT_W-1:0]     hi;
  logic                 in_range;
  logic [WORD_W-1:0]    cand;
  logic [BIT_W-1:0]     hit_idx;
  logic [VALUE_W-1:0]   prime;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [WORD_W-1:0]    wr_data;
  logic [ADDR_W-1:0]    rd_addr;
  logic [WORD_W-1:0]    rd_data;

  // Effective limit, saturated at the bitmap size.
  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= LIM_RESET;
    end else if (cmd.lim_load) begin
      lim <= (32'(sieve_limit) > MAX_V32) ? LIM_RESET : sieve_limit;
    end
  end

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_init) begin
      clr_cnt <= '0;
    end else if (cmd.clr_write) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Sieve base and multiple registers.
  always_ff @(posedge clk) begin
    if (cmd.i_init) begin
      i <= FIRST_PRIME;
    end else if (cmd.i_inc) begin
      i <= i + 1'b1;
    end
    if (cmd.j_load) begin
      j <= sq[VALUE_W:0];
    end else if (cmd.j_inc) begin
      j <= j + (VALUE_W+1)'(i);
    end
  end

  // Query and scan position.
  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      q         <= query_value;
      scan_word <= query_value[VALUE_W-1:BIT_W];
    end else if (cmd.scan_next) begin
      scan_word <= scan_word_inc;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      found      <= sts.scan_hit;
      next_prime <= sts.scan_hit ? prime : '0;
      prime_gap  <= sts.scan_hit ? (prime - q) : '0;
    end
  end

  // Sieve status.
  assign sq              = i * i;
  assign sts.clr_last    = (clr_cnt == CLR_LAST);
  assign sts.sq_over     = sq > (2*I_W)'(lim);
  assign sts.i_composite = rd_data[i[BIT_W-1:0]];
  assign sts.j_over      = j > {1'b0, lim};

  // Word scan: lowest clear bit between the query and the limit.
  assign scan_word_inc = scan_word + 1'b1;
  assign q_word        = q[VALUE_W-1:BIT_W];
  assign lim_word      = lim[VALUE_W-1:BIT_W];
  assign lo            = (scan_word == q_word) ? q[BIT_W-1:0] : '0;
  assign hi            = (scan_word == lim_word) ? lim[BIT_W-1:0] : TOP_BIT;
  assign in_range      = (scan_word <= lim_word);
  assign cand          = ~rd_data & (ONES << lo) & (ONES >> (TOP_BIT - hi))
                         & {WORD_W{in_range}};
  assign sts.scan_hit  = |cand;
  assign sts.scan_end  = (scan_word >= lim_word);
  assign prime         = VALUE_W'({scan_word, hit_idx});

  always_comb begin
    hit_idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        hit_idx = BIT_W'(b);
      end
    end
  end

  // Bitmap write port: clearing pass or crossing off a multiple.
  always_comb begin
    wr_en   = cmd.clr_write || cmd.mark_write;
    wr_addr = ADDR_W'(j[VALUE_W:BIT_W]);
    wr_data = rd_data | (WORD_W'(1) << j[BIT_W-1:0]);
    if (cmd.clr_write) begin
      wr_addr = clr_cnt;
      wr_data = (clr_cnt == '0) ? LOW_NONPRIME : '0;
    end
  end

  // Bitmap read address.
  always_comb begin
    unique case (cmd.rd_sel)
      RD_I:         rd_addr = ADDR_W'(i[I_W-1:BIT_W]);
      RD_J:         rd_addr = ADDR_W'(j[VALUE_W:BIT_W]);
      RD_QUERY:     rd_addr = ADDR_W'(query_value[VALUE_W-1:BIT_W]);
      RD_SCAN:      rd_addr = ADDR_W'(scan_word);
      RD_SCAN_NEXT: rd_addr = ADDR_W'(scan_word_inc);
      default:      rd_addr = '0;
    endcase
  end

  psq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// File: rtl/core/prime_sieve_next_prime_query_unit.sv
// Next-prime query unit backed by a sieve of Eratosthenes bitmap.
// Input channel: in_valid / in_stall with query_value; a transaction moves one query.
// Output channel: out_valid / out_stall with next_prime, prime_gap and found; one
// result transaction per query, in order. found is 0 with both values 0 when no
// prime lies between the query and the limit.
// Limit channel: cfg_valid / cfg_ready with sieve_limit; a write rebuilds the bitmap.
// Reset (rst, synchronous) sets the limit to MAX_VALUE capped at 65535 and rebuilds
// the bitmap: a clearing pass over its MAX_VALUE/32+1 words (2048 by default), then
// a read and a write per crossed-off multiple. in_stall is high throughout; the
// same rebuild follows every limit write.
// A query scans W 32-bit bitmap words, one per cycle through the registered read
// port; below 65536 W is at most 4.
// The result sits in an output register, so a new query is taken while it waits;
// if out_stall holds that result, the next scan finishes and then waits for it.
module prime_sieve_next_prime_query_unit #(
  parameter int MAX_VALUE = 65535
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [psq_pkg::VALUE_W-1:0] query_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [psq_pkg::VALUE_W-1:0] next_prime,
  output logic [psq_pkg::VALUE_W-1:0] prime_gap,
  output logic                        found,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [psq_pkg::VALUE_W-1:0] sieve_limit
);
  import psq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  psq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  psq_dp #(
    .MAX_VALUE (MAX_VALUE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .query_value (query_value),
    .sieve_limit (sieve_limit),
    .next_prime  (next_prime),
    .prime_gap   (prime_gap),
    .found       (found)
  );

endmodule

// File: dv/prime_sieve_next_prime_query_unit_tb.sv
module prime_sieve_next_prime_query_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psq_pkg::*;

  localparam int MAX_VALUE = 65535;
  // Nothing is accepted during a full rebuild of the bitmap.
  localparam int STALL_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MISMATCH_REPORTS = 10;

  typedef struct packed {
    logic [VALUE_W-1:0] prime;
    logic [VALUE_W-1:0] gap;
    logic               found;
  } answer_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] query_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [VALUE_W-1:0] next_prime;
  logic [VALUE_W-1:0] prime_gap;
  logic               found;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [VALUE_W-1:0] sieve_limit = '0;

  // Predictor state: the limit register and its composite bitmap.
  logic [VALUE_W-1:0] limit_setting;
  bit                 composite_map [0:MAX_VALUE];

  answer_t pending_answers [$];

  int send_gap_pct = 0;
  int result_stall_pct = 0;
  int stall_hold_left = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;

  prime_sieve_next_prime_query_unit #(
    .MAX_VALUE(MAX_VALUE)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .query_value(query_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .next_prime (next_prime),
    .prime_gap  (prime_gap),
    .found      (found),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .sieve_limit(sieve_limit)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Rebuild the composite bitmap up to the current limit.
  function automatic void rebuild_composite_map();
    int i;
    int j;
    int lim;
    lim = limit_setting;
    for (i = 0; i <= MAX_VALUE; i++) composite_map[i] = 1'b0;
    composite_map[0] = 1'b1;
    composite_map[1] = 1'b1;
    for (i = 2; i * i <= lim; i++) begin
      if (!composite_map[i]) begin
        for (j = i * i; j <= lim; j += i) composite_map[j] = 1'b1;
      end
    end
  endfunction

  // Smallest prime between the query and the limit, or a not-found answer.
  function automatic answer_t next_prime_at_or_above(input logic [VALUE_W-1:0] q);
    answer_t ans;
    int v;
    ans = '0;
    if (limit_setting < 2) return ans;
    for (v = q; v <= limit_setting; v++) begin
      if (!composite_map[v]) begin
        ans.prime = v[VALUE_W-1:0];
        ans.gap = VALUE_W'(v - q);
        ans.found = 1'b1;
        return ans;
      end
    end
    return ans;
  endfunction

  function automatic void note_mismatch(input string what, input logic [VALUE_W-1:0] want,
                                        input logic [VALUE_W-1:0] got);
    if (mismatch_count < MISMATCH_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, what, want, got);
    mismatch_count++;
  endfunction

  // Offer one query, with random idle cycles ahead of it, and wait for the transaction.
  task automatic send_query(input logic [VALUE_W-1:0] q);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    query_value <= q;
    do @(posedge clk); while (in_stall);
    pending_answers = {pending_answers, next_prime_at_or_above(q)};
  endtask

  // Write the limit once every outstanding result has come back.
  task automatic write_limit(input logic [VALUE_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    sieve_limit <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_setting = value;
    rebuild_composite_map();
  endtask

  // Mostly values within the limit, some around it, some anywhere in the field.
  function automatic logic [VALUE_W-1:0] pick_query();
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 70) begin
      v = $urandom_range(int'(limit_setting));
    end else if (pick < 85) begin
      v = int'(limit_setting) - 40 + $urandom_range(80);
      if (v < 0) v = 0;
      if (v > MAX_VALUE) v = MAX_VALUE;
    end else begin
      v = $urandom_range(MAX_VALUE);
    end
    return v[VALUE_W-1:0];
  endfunction

  // Field extremes, prime boundaries and long gaps over the full range.
  task automatic test_full_range_directed();
    logic [VALUE_W-1:0] queries [$];
    queries = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd24, 16'd114, 16'd31398,
                16'd65519, 16'd65521, 16'd65522, 16'hFFFF, 16'h5555, 16'hAAAA};
    send_gap_pct = 0;
    result_stall_pct = 0;
    foreach (queries[k]) send_query(queries[k]);
  endtask

  // Limits at three and below, where few or no primes are covered.
  task automatic test_tiny_limits();
    write_limit(16'd2);
    send_query(16'd0);
    send_query(16'd1);
    send_query(16'd2);
    send_query(16'd3);
    write_limit(16'd1);
    send_query(16'd1);
    send_query(16'd0);
    write_limit(16'd0);
    send_query(16'd0);
    send_query(16'hFFFF);
    write_limit(16'd3);
    send_query(16'd2);
    send_query(16'd3);
  endtask

  // Random queries under one limit and one idling pattern.
  task automatic test_random_queries(input logic [VALUE_W-1:0] lim, input int gap_pct,
                                     input int stall_pct, input int count);
    write_limit(lim);
    send_gap_pct = gap_pct;
    result_stall_pct = stall_pct;
    repeat (count) send_query(pick_query());
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_output_backpressure();
    send_gap_pct = 0;
    result_stall_pct = 0;
    stall_hold_left = 400;
    repeat (30) send_query(pick_query());
  endtask

  // Check each result transaction against the oldest expectation, then pick the next stall.
  always @(posedge clk) begin : result_checker
    answer_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        if (mismatch_count < MISMATCH_REPORTS)
          $display("%0t: result with no query outstanding, next_prime %0d", $realtime,
                   next_prime);
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        if (next_prime !== want.prime) note_mismatch("next_prime", want.prime, next_prime);
        if (prime_gap !== want.gap) note_mismatch("prime_gap", want.gap, prime_gap);
        if (found !== want.found) note_mismatch("found", VALUE_W'(want.found), VALUE_W'(found));
      end
    end
    if (stall_hold_left > 0) begin
      out_stall <= 1'b1;
      stall_hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < result_stall_pct);
    end
  end

  // End the run when nothing has been accepted for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    limit_setting = LIMIT_RESET;
    rebuild_composite_map();

    test_full_range_directed();
    test_tiny_limits();
    test_random_queries(16'd1000, 0, 0, 230);
    test_random_queries(16'd4093, 88, 0, 230);
    test_random_queries(16'd200, 0, 88, 230);
    test_random_queries(16'd20000, 37, 37, 230);
    test_random_queries(16'hFFFF, 0, 0, 200);
    test_output_backpressure();

    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
